// ===== src/mdc_pkg.sv =====
package mdc_pkg;

  // Default sizes of the delay memory and of the audio samples.
  localparam int DELAY_DEPTH_DEF = 131072;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed field widths.
  localparam int TARGET_W = 17;
  localparam int GAIN_W   = 16;
  localparam int CHOFS_W  = 19;
  localparam int LFO_W    = 17;
  localparam int CUR_W    = 41;   // smoothed delay, Q17.24 samples
  localparam int DIFF_W   = CUR_W + 1;
  localparam int FRAC_W   = 8;    // tap positions carry 1/256 sample

  // Fixed-point constants.
  localparam int SMOOTH_COEF  = 3355;   // about 0.0002 in Q0.24
  localparam int SMOOTH_SHIFT = 24;
  localparam int BASE_SHIFT   = 16;     // Q17.24 down to 1/256 samples
  localparam int GAIN_SHIFT   = 15;
  localparam int SIXTENTHS    = 19661;  // 0.6 in Q0.15

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CHOFS_W;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHORUS_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHORUS_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS        = 3'd5;

  localparam logic [TARGET_W-1:0] DELAY_TARGET_RST  = 17'd4800;
  localparam logic [CHOFS_W-1:0]  CHORUS_OFFSET_RST = 19'd36864;

  typedef struct packed {
    logic [TARGET_W-1:0] delay_target;
    logic [GAIN_W-1:0]   feedback_gain;
    logic [CHOFS_W-1:0]  chorus_offset;
    logic [GAIN_W-1:0]   mix_gain;
    logic                chorus_mode;
    logic                bypass;
  } cfg_t;

endpackage

// ===== src/mdc_cfg.sv =====
module mdc_cfg import mdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_target  <= DELAY_TARGET_RST;
      cfg.feedback_gain <= '0;
      cfg.chorus_offset <= CHORUS_OFFSET_RST;
      cfg.mix_gain      <= '0;
      cfg.chorus_mode   <= 1'b0;
      cfg.bypass        <= 1'b1;
    end else if (cfg_we) begin
      // Indices beyond the register list are ignored.
      unique case (cfg_index)
        REG_DELAY_TARGET:  cfg.delay_target  <= cfg_data[TARGET_W-1:0];
        REG_FEEDBACK_GAIN: cfg.feedback_gain <= cfg_data[GAIN_W-1:0];
        REG_CHORUS_OFFSET: cfg.chorus_offset <= cfg_data[CHOFS_W-1:0];
        REG_MIX_GAIN:      cfg.mix_gain      <= cfg_data[GAIN_W-1:0];
        REG_CHORUS_MODE:   cfg.chorus_mode   <= cfg_data[0];
        REG_BYPASS:        cfg.bypass        <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/mdc_delay_mem.sv =====
module mdc_delay_mem import mdc_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int ADDR_W = $clog2(DELAY_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic signed [SAMPLE_BITS-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] wr_data
);

  logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/mdc_out_reg.sv =====
module mdc_out_reg import mdc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] push_data,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  // The register can take a new result when empty or when its beat leaves now.
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_sample <= push_data;
    end
  end

endmodule

// ===== src/mdc_core.sv =====
module mdc_core import mdc_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int ADDR_W = $clog2(DELAY_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic signed [LFO_W-1:0]       lfo_offset,
  output logic                          mem_rd_en,
  output logic [ADDR_W-1:0]             mem_rd_addr,
  input  logic signed [SAMPLE_BITS-1:0] mem_rd_data,
  output logic                          mem_wr_en,
  output logic [ADDR_W-1:0]             mem_wr_addr,
  output logic signed [SAMPLE_BITS-1:0] mem_wr_data,
  output logic                          res_push,
  output logic signed [SAMPLE_BITS-1:0] res_data,
  input  logic                          res_free
);

  localparam int POS_W   = ADDR_W + FRAC_W;
  localparam int WET_W   = SAMPLE_BITS + 2;
  localparam int SUM_W   = SAMPLE_BITS + 4;
  localparam int MA_W    = (DIFF_W > SUM_W) ? DIFF_W : SUM_W;
  localparam int MB_W    = GAIN_W + 1;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int STATE_W = 5;

  localparam logic [STATE_W-1:0] S_IDLE  = 5'd0;
  localparam logic [STATE_W-1:0] S_SMUL  = 5'd1;
  localparam logic [STATE_W-1:0] S_SUPD  = 5'd2;
  localparam logic [STATE_W-1:0] S_TAPS  = 5'd3;
  localparam logic [STATE_W-1:0] S_READ  = 5'd4;
  localparam logic [STATE_W-1:0] S_RLAST = 5'd5;
  localparam logic [STATE_W-1:0] S_IMUL1 = 5'd6;
  localparam logic [STATE_W-1:0] S_IADD1 = 5'd7;
  localparam logic [STATE_W-1:0] S_IMUL2 = 5'd8;
  localparam logic [STATE_W-1:0] S_IADD2 = 5'd9;
  localparam logic [STATE_W-1:0] S_WMUL  = 5'd10;
  localparam logic [STATE_W-1:0] S_WSH   = 5'd11;
  localparam logic [STATE_W-1:0] S_CMUL  = 5'd12;
  localparam logic [STATE_W-1:0] S_CSH   = 5'd13;
  localparam logic [STATE_W-1:0] S_MMUL  = 5'd14;
  localparam logic [STATE_W-1:0] S_MADD  = 5'd15;
  localparam logic [STATE_W-1:0] S_DONE  = 5'd16;

  // Read slots: first tap's a and b, then second tap's a and b.
  localparam logic [1:0] SLOT_A1 = 2'd0;
  localparam logic [1:0] SLOT_B1 = 2'd1;
  localparam logic [1:0] SLOT_A2 = 2'd2;
  localparam logic [1:0] SLOT_B2 = 2'd3;

  localparam logic signed [SUM_W-1:0] SAT_HI = {{5{1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = {{5{1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = SAMPLE_BITS'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = SAMPLE_BITS'(SAT_LO);
    end else begin
      r = SAMPLE_BITS'(v);
    end
    return r;
  endfunction

  logic [STATE_W-1:0]             state;
  logic signed [SAMPLE_BITS-1:0]  x_r;
  logic signed [LFO_W-1:0]        lfo_r;
  logic signed [DIFF_W-1:0]       diff_r;
  logic signed [PROD_W-1:0]       prod;
  logic [CUR_W-1:0]               cur;
  logic [ADDR_W-1:0]              wp;
  logic [ADDR_W:0]                fill;
  logic [ADDR_W-1:0]              tap_a_ip, tap_b_ip;
  logic [FRAC_W-1:0]              tap_a_f, tap_b_f;
  logic [1:0]                     rd_cnt;
  logic                           pend;
  logic [1:0]                     pend_slot;
  logic                           pend_ok;
  logic signed [SAMPLE_BITS-1:0]  a1, b1, a2, b2;
  logic signed [SAMPLE_BITS-1:0]  r1;
  logic signed [SAMPLE_BITS:0]    rsum;
  logic signed [WET_W-1:0]        wet;
  logic signed [SAMPLE_BITS-1:0]  res;

  logic signed [MA_W-1:0]         mul_a;
  logic signed [MB_W-1:0]         mul_b;
  logic signed [SAMPLE_BITS:0]    dab1, dab2;
  logic [POS_W-1:0]               base_p, lfo_p, ofs_p, tap_a, tap_b;
  logic [ADDR_W-1:0]              rd_ip, rd_off;
  logic                           rd_ok;
  logic [1:0]                     rd_last;
  logic                           accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign res_push = (state == S_DONE) && res_free;
  assign res_data = res;

  // Tap positions, taken modulo the span of the memory in 1/256 samples.
  assign base_p = POS_W'(cur >> BASE_SHIFT);
  assign lfo_p  = POS_W'(lfo_r);
  assign ofs_p  = POS_W'(cfg.chorus_offset);
  assign tap_b  = base_p + lfo_p + ofs_p;
  assign tap_a  = cfg.chorus_mode ? base_p : base_p + lfo_p;

  // An entry at offset k from the write pointer has been written if
  // 1 <= k <= fill, or for any k once every entry has been written; anything
  // else is read as zero.
  assign rd_ip       = rd_cnt[1] ? tap_b_ip : tap_a_ip;
  assign rd_off      = rd_ip + ADDR_W'(rd_cnt[0]);
  assign rd_ok       = fill[ADDR_W] || ((rd_off != '0) && ({1'b0, rd_off} <= fill));
  assign rd_last     = cfg.chorus_mode ? SLOT_B2 : SLOT_B1;
  assign mem_rd_en   = (state == S_READ);
  assign mem_rd_addr = wp + rd_off;

  assign mem_wr_en   = (state == S_MMUL);
  assign mem_wr_addr = wp;
  assign mem_wr_data = sat(SUM_W'(x_r) + SUM_W'(wet));

  assign dab1 = (SAMPLE_BITS+1)'(b1) - (SAMPLE_BITS+1)'(a1);
  assign dab2 = (SAMPLE_BITS+1)'(b2) - (SAMPLE_BITS+1)'(a2);

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SMUL: begin
        mul_a = MA_W'(diff_r);
        mul_b = MB_W'(SMOOTH_COEF);
      end
      S_IMUL1: begin
        mul_a = MA_W'(dab1);
        mul_b = MB_W'({1'b0, tap_a_f});
      end
      S_IMUL2: begin
        mul_a = MA_W'(dab2);
        mul_b = MB_W'({1'b0, tap_b_f});
      end
      S_WMUL: begin
        mul_a = cfg.chorus_mode ? MA_W'(rsum) : MA_W'(r1);
        mul_b = MB_W'({1'b0, cfg.feedback_gain});
      end
      S_CMUL: begin
        mul_a = MA_W'(wet);
        mul_b = MB_W'(SIXTENTHS);
      end
      S_MMUL: begin
        mul_a = MA_W'(wet);
        mul_b = MB_W'({1'b0, cfg.mix_gain});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer and the persistent delay state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cur    <= '0;
      wp     <= '0;
      fill   <= '0;
      rd_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= cfg.bypass ? S_DONE : S_SMUL;
          end
        end
        S_SMUL: state <= S_SUPD;
        S_SUPD: begin
          cur   <= CUR_W'($signed({1'b0, cur}) + (prod >>> SMOOTH_SHIFT));
          state <= S_TAPS;
        end
        S_TAPS: state <= S_READ;
        S_READ: begin
          if (rd_cnt == rd_last) begin
            rd_cnt <= '0;
            state  <= S_RLAST;
          end else begin
            rd_cnt <= rd_cnt + 2'd1;
          end
        end
        S_RLAST: state <= S_IMUL1;
        S_IMUL1: state <= S_IADD1;
        S_IADD1: state <= cfg.chorus_mode ? S_IMUL2 : S_WMUL;
        S_IMUL2: state <= S_IADD2;
        S_IADD2: state <= S_WMUL;
        S_WMUL:  state <= S_WSH;
        S_WSH:   state <= cfg.chorus_mode ? S_CMUL : S_MMUL;
        S_CMUL:  state <= S_CSH;
        S_CSH:   state <= S_MMUL;
        S_MMUL: begin
          wp <= wp - ADDR_W'(1);
          if (fill != (ADDR_W+1)'(DELAY_DEPTH)) begin
            fill <= fill + (ADDR_W+1)'(1);
          end
          state <= S_MADD;
        end
        S_MADD: state <= S_DONE;
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= (state == S_READ);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pend_slot <= rd_cnt;
    pend_ok   <= rd_ok;
    if (pend) begin
      unique case (pend_slot)
        SLOT_A1: a1 <= pend_ok ? mem_rd_data : '0;
        SLOT_B1: b1 <= pend_ok ? mem_rd_data : '0;
        SLOT_A2: a2 <= pend_ok ? mem_rd_data : '0;
        SLOT_B2: b2 <= pend_ok ? mem_rd_data : '0;
        default: ;
      endcase
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          x_r    <= in_sample;
          lfo_r  <= lfo_offset;
          diff_r <= $signed({1'b0, cfg.delay_target, {SMOOTH_SHIFT{1'b0}}})
                    - $signed({1'b0, cur});
          res    <= in_sample;
        end
      end
      S_TAPS: begin
        tap_a_ip <= tap_a[POS_W-1:FRAC_W];
        tap_a_f  <= tap_a[FRAC_W-1:0];
        tap_b_ip <= tap_b[POS_W-1:FRAC_W];
        tap_b_f  <= tap_b[FRAC_W-1:0];
      end
      S_IADD1: r1 <= SAMPLE_BITS'(a1 + (prod >>> FRAC_W));
      S_IADD2: rsum <= (SAMPLE_BITS+1)'(r1) + (SAMPLE_BITS+1)'(a2 + (prod >>> FRAC_W));
      S_WSH:   wet <= WET_W'(prod >>> GAIN_SHIFT);
      S_CSH:   wet <= WET_W'(prod >>> GAIN_SHIFT);
      S_MADD:  res <= sat(SUM_W'(x_r) + SUM_W'(prod >>> GAIN_SHIFT));
      default: ;
    endcase
  end

endmodule

// ===== src/modulated_delay_chorus_top.sv =====
// Modulated delay line for chorus and vibrato.
// Input channel: in_valid with in_sample and lfo_offset, held off by in_stall. Output
// channel: out_valid with out_sample, held off by out_stall. A beat moves on a rising
// edge where valid is high and stall is low. Registers are written through cfg_we,
// cfg_index and cfg_data, one per cycle; the user must write them only while no item is
// in flight, as the block does not enforce this. One item is worked on at a time by a
// sequencer around a single multiplier and a delay memory with one read and one write
// port. Each item runs the delay smoother, reads the taps (two memory reads per tap, one
// read per cycle), interpolates, scales and writes the new sample back; the next item is
// taken only once the result has been handed to the output register. In bypass the
// input beat is registered and then passed through the output register; memory and
// delay state are left untouched.
// The finished result sits in an output register, so a stall on the output only holds
// the sequencer once a further result is ready while the previous one is still there.
// Reset returns the registers to their defaults (bypass on) and empties the line: a
// count of written entries makes unwritten entries read as zero, so no clearing pass
// is needed and the block takes items in the first cycle after reset.
// DELAY_DEPTH must be a power of two.
module modulated_delay_chorus_top import mdc_pkg::*; #(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic signed [LFO_W-1:0]       lfo_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  localparam int ADDR_W = $clog2(DELAY_DEPTH);

  cfg_t                          cfg;
  logic                          mem_rd_en;
  logic [ADDR_W-1:0]             mem_rd_addr;
  logic signed [SAMPLE_BITS-1:0] mem_rd_data;
  logic                          mem_wr_en;
  logic [ADDR_W-1:0]             mem_wr_addr;
  logic signed [SAMPLE_BITS-1:0] mem_wr_data;
  logic                          res_push;
  logic signed [SAMPLE_BITS-1:0] res_data;
  logic                          res_free;

  // Configuration registers.
  mdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Delay memory: one registered read and one write per cycle.
  mdc_delay_mem #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Sequencer, shared multiplier and the smoothed delay and write pointer.
  mdc_core #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .lfo_offset  (lfo_offset),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .res_push    (res_push),
    .res_data    (res_data),
    .res_free    (res_free)
  );

  // Output register decoupling the sequencer from the receiver.
  mdc_out_reg #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (res_push),
    .push_data  (res_data),
    .free       (res_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

endmodule

// ===== src/mdc_checker.sv =====
module mdc_checker import mdc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_sample
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_sample))
    else $error("stalled output beat changed");

  // After reset nothing is pending and the input is open.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again while an item is in flight");

  // With nothing in flight and nothing accepted, no result can appear.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_stall && !in_valid |=> !out_valid)
    else $error("result appeared without an item");

endmodule

bind modulated_delay_chorus_top mdc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mdc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_sample (out_sample)
);

// ===== dv/modulated_delay_chorus_top_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the modulated delay line. The bench carries its own model of the
// echo memory, the write head and the slewed delay length. That model is advanced once for
// every input beat that the block accepts. Each output beat is checked against the oldest
// predicted sample. Stimulus is queued by the sequence below, driven at the falling edge and
// observed at the rising edge.
module modulated_delay_chorus_top_tb;
  import mdc_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int LINE_DEPTH = DELAY_DEPTH_DEF;
  localparam int POS_W = $clog2(LINE_DEPTH);

  // Tap positions are in 1/256 sample, so the line spans LINE_DEPTH * 256 steps.
  localparam longint SPAN_MASK = longint'(LINE_DEPTH) * 256 - 1;
  localparam longint GLIDE_MASK = (longint'(1) << 41) - 1;
  localparam longint GLIDE_COEF = 3355;   // roughly 0.0002 in Q0.24
  localparam longint POINT_SIX = 19661;   // 0.6 in Q0.15
  localparam longint SAMPLE_MAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam longint LFO_MAX = (longint'(1) << (LFO_W - 1)) - 1;
  localparam longint LFO_MIN = -LFO_MAX - 1;
  localparam int LFO_SWING = 36864;

  // Register indexes past the end of the map; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int HOLD_AT = 830;    // beats accepted before the long output hold-off
  localparam int HOLD_LEN = 300;
  localparam int SETTLE = 40;      // quiet cycles once every result has come back

  typedef struct packed {
    logic signed [SW-1:0]    sample;
    logic signed [LFO_W-1:0] lfo;
  } beat_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [SW-1:0] in_sample;
  logic signed [LFO_W-1:0] lfo_offset;
  logic out_valid;
  logic out_stall;
  logic signed [SW-1:0] out_sample;

  modulated_delay_chorus_top #(
    .DELAY_DEPTH(LINE_DEPTH),
    .SAMPLE_BITS(SW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .lfo_offset(lfo_offset),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample(out_sample)
  );

  always #5 clk = ~clk;

  // Beats waiting to be offered, and output samples predicted but not yet seen.
  beat_t audio_backlog[$];
  logic signed [SW-1:0] due_samples[$];

  int send_gap_pct;
  int stall_pct;
  int mismatches = 0;
  int beats_in = 0;
  logic in_fired = 1'b0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int unsigned cycle_count = 0;
  int lfo_track = 0;

  // Model state: the echo memory (2-state, so it starts out all zeros as after reset),
  // the write head, the slewed delay in Q17.24 samples and the register settings.
  int echo_line[LINE_DEPTH];
  logic [POS_W-1:0] head_pos = '0;
  longint glide_delay = 0;
  cfg_t live_cfg;

  function automatic cfg_t settings(int unsigned tgt, int unsigned fbk, int unsigned ofs,
                                    int unsigned mix, logic mode, logic byp);
    cfg_t c;
    c.delay_target = tgt[TARGET_W-1:0];
    c.feedback_gain = fbk[GAIN_W-1:0];
    c.chorus_offset = ofs[CHOFS_W-1:0];
    c.mix_gain = mix[GAIN_W-1:0];
    c.chorus_mode = mode;
    c.bypass = byp;
    return c;
  endfunction

  function automatic longint clamp_sample(longint v);
    if (v > SAMPLE_MAX) begin
      return SAMPLE_MAX;
    end
    if (v < SAMPLE_MIN) begin
      return SAMPLE_MIN;
    end
    return v;
  endfunction

  // Linear interpolation between two neighbouring entries. The position wraps round the
  // whole line, so negative and over-long delays land in wrapped memory.
  function automatic longint tap_value(longint d);
    longint w;
    longint f;
    longint a;
    longint b;
    logic [POS_W-1:0] p0;
    logic [POS_W-1:0] p1;
    w = d & SPAN_MASK;
    f = w & 255;
    p0 = head_pos + w[POS_W+7:8];
    p1 = p0 + 1'b1;
    a = echo_line[p0];
    b = echo_line[p1];
    return a + (((b - a) * f) >>> 8);
  endfunction

  // Advances the model by one accepted beat and returns the sample the block should emit.
  function automatic logic signed [SW-1:0] next_out_sample(logic signed [SW-1:0] s_in,
                                                           logic signed [LFO_W-1:0] l_in);
    longint x;
    longint lfo;
    longint tgt;
    longint fbk;
    longint mix;
    longint ofs;
    longint diff;
    longint base;
    longint wet;
    longint y;
    x = $signed(s_in);
    lfo = $signed(l_in);
    tgt = live_cfg.delay_target;
    fbk = live_cfg.feedback_gain;
    mix = live_cfg.mix_gain;
    ofs = live_cfg.chorus_offset;
    if (live_cfg.bypass) begin
      return s_in;
    end
    diff = (tgt << 24) - glide_delay;
    glide_delay = (glide_delay + ((diff * GLIDE_COEF) >>> 24)) & GLIDE_MASK;
    base = glide_delay >>> 16;
    if (live_cfg.chorus_mode) begin
      wet = (((fbk * (tap_value(base) + tap_value(base + ofs + lfo))) >>> 15) * POINT_SIX)
            >>> 15;
    end else begin
      wet = (fbk * tap_value(base + lfo)) >>> 15;
    end
    echo_line[head_pos] = int'(clamp_sample(x + wet));
    head_pos = head_pos - 1'b1;
    y = clamp_sample(x + ((mix * wet) >>> 15));
    return y[SW-1:0];
  endfunction

  function automatic void queue_beat(longint s, longint l);
    beat_t b;
    b.sample = s[SW-1:0];
    b.lfo = l[LFO_W-1:0];
    audio_backlog.push_back(b);
  endfunction

  // Random content shaped like real use: the modulation mostly wanders slowly within its
  // nominal swing, with the odd jump anywhere in the field. Samples are mostly full-scale
  // noise, with quiet passages and rail values mixed in.
  function automatic void queue_random_beat();
    longint s;
    longint l;
    lfo_track = lfo_track + int'($urandom_range(4096)) - 2048;
    if (lfo_track > LFO_SWING) begin
      lfo_track = LFO_SWING;
    end else if (lfo_track < -LFO_SWING) begin
      lfo_track = -LFO_SWING;
    end
    l = ($urandom_range(99) < 15) ? longint'($urandom()) : longint'(lfo_track);
    case ($urandom_range(19))
      0: s = SAMPLE_MAX;
      1: s = SAMPLE_MIN;
      2, 3: s = longint'($urandom_range(2048)) - 1024;
      default: s = longint'($urandom());
    endcase
    queue_beat(s, l);
  endfunction

  // Input side: acceptance and prediction at the rising edge. Output side: every beat is
  // matched against the oldest prediction.
  always @(posedge clk) begin
    logic signed [SW-1:0] want;
    in_fired <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      due_samples.push_back(next_out_sample(in_sample, lfo_offset));
      beats_in <= beats_in + 1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (due_samples.size() == 0) begin
        $display("%0t: out_sample %0d arrived with nothing expected", $time, out_sample);
        mismatches++;
      end else begin
        want = due_samples.pop_front();
        if (out_sample !== want) begin
          $display("%0t: out_sample expected %0d actual %0d", $time, want, out_sample);
          mismatches++;
        end
      end
    end
  end

  // Sender: a beat stays on the port until taken, then the next one may follow or a gap
  // may be left, as the current idle rate decides.
  always @(negedge clk) begin
    beat_t nxt;
    if (!in_valid || in_fired) begin
      if (audio_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = audio_backlog.pop_front();
        in_valid <= 1'b1;
        in_sample <= nxt.sample;
        lfo_offset <= nxt.lfo;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off part way through a phase in which the
  // sender never idles, so that the block backs up and must stall its input.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modulated_delay_chorus_top verification failed");
      $finish;
    end
  end

  // Upper data bits beyond the register width are filled with junk, which the block must
  // drop just as the model does.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value, int width);
    logic [31:0] raw;
    raw = ($urandom() << width) | value;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= raw[CFG_DATA_W-1:0];
    case (idx)
      REG_DELAY_TARGET: live_cfg.delay_target = raw[TARGET_W-1:0];
      REG_FEEDBACK_GAIN: live_cfg.feedback_gain = raw[GAIN_W-1:0];
      REG_CHORUS_OFFSET: live_cfg.chorus_offset = raw[CHOFS_W-1:0];
      REG_MIX_GAIN: live_cfg.mix_gain = raw[GAIN_W-1:0];
      REG_CHORUS_MODE: live_cfg.chorus_mode = raw[0];
      REG_BYPASS: live_cfg.bypass = raw[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(cfg_t c, bit poke_spare);
    write_reg(REG_DELAY_TARGET, c.delay_target, TARGET_W);
    write_reg(REG_FEEDBACK_GAIN, c.feedback_gain, GAIN_W);
    write_reg(REG_CHORUS_OFFSET, c.chorus_offset, CHOFS_W);
    write_reg(REG_MIX_GAIN, c.mix_gain, GAIN_W);
    write_reg(REG_CHORUS_MODE, c.chorus_mode, 1);
    write_reg(REG_BYPASS, c.bypass, 1);
    if (poke_spare) begin
      write_reg(REG_SPARE_LO, 0, 0);
      write_reg(REG_SPARE_HI, 0, 0);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued beat has gone in and every result has come out. The state is
  // looked at on the rising edge, where the sender is not active.
  task automatic settle();
    while (audio_backlog.size() != 0 || in_valid || due_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_random(cfg_t c, int n, int gap, int stall);
    settle();
    apply_settings(c, 1'b0);
    send_gap_pct = gap;
    stall_pct = stall;
    repeat (n) queue_random_beat();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_sample = '0;
    lfo_offset = '0;
    out_stall = 1'b0;
    live_cfg = settings(4800, 0, 36864, 0, 1'b0, 1'b1);
    send_gap_pct = 12;
    stall_pct = 45;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Straight after reset the block is in bypass: beats pass untouched and state is frozen.
    queue_beat(SAMPLE_MAX, LFO_MAX);
    queue_beat(SAMPLE_MIN, LFO_MIN);
    queue_beat(0, 0);

    // Vibrato with a zero target, so the delay stays at zero and the tap is steered by the
    // modulation alone: zero delay reads the entry about to be overwritten, one sample reads
    // the newest, half a sample interpolates, negative and far delays wrap. Gains close to
    // two drive the feedback and the output into saturation.
    settle();
    apply_settings(settings(0, 65535, 0, 65535, 1'b0, 1'b0), 1'b0);
    queue_beat(SAMPLE_MAX, 0);
    queue_beat(SAMPLE_MIN, 256);
    queue_beat(12345, 128);
    queue_beat(-1, 255);
    queue_beat(0, 512);
    queue_beat(SAMPLE_MAX, -256);
    queue_beat(SAMPLE_MIN, LFO_MAX);
    queue_beat(4096, LFO_MIN);
    queue_beat(-4096, LFO_SWING);
    queue_beat(1, -LFO_SWING);

    // Chorus with the second tap one sample behind the first; the spare indexes are written
    // as well and must change nothing.
    settle();
    apply_settings(settings(0, 65535, 256, 65535, 1'b1, 1'b0), 1'b1);
    queue_beat(SAMPLE_MAX, 0);
    queue_beat(SAMPLE_MIN, 0);
    queue_beat(SAMPLE_MAX, 256);
    queue_beat(-1, -256);
    queue_beat(0, LFO_MAX);
    queue_beat(SAMPLE_MIN, LFO_MIN);
    queue_beat(SAMPLE_MAX, 100);
    queue_beat(SAMPLE_MIN, -100);

    // Random phases. The sender idles lightly against a busy receiver first, then the other
    // way round, and finally neither side idles apart from the one long hold-off.
    run_random(settings(4800, $urandom_range(32768, 16384), 36864, $urandom_range(32768),
                        1'b0, 1'b0), 250, 12, 45);
    run_random(settings(4800, $urandom_range(32768, 16384), $urandom_range(307200, 36864),
                        $urandom_range(32768), 1'b1, 1'b0), 150, 12, 45);
    run_random(settings($urandom_range(131071), $urandom_range(65535), $urandom_range(524287),
                        $urandom_range(65535), 1'b1, 1'b1), 50, 45, 12);
    run_random(settings(86400, 32768, 307200, 32768, 1'b1, 1'b0), 200, 45, 12);
    run_random(settings(131071, 0, 36864, 0, 1'b0, 1'b0), 100, 0, 0);
    run_random(settings(0, 65535, 524287, 65535, 1'b1, 1'b0), 150, 0, 0);
    run_random(settings($urandom_range(131071), $urandom_range(65535), $urandom_range(524287),
                        $urandom_range(65535), 1'b0, 1'b0), 150, 0, 0);

    settle();
    if (mismatches == 0) begin
      $display("modulated_delay_chorus_top verification clean");
    end else begin
      $display("modulated_delay_chorus_top verification failed");
    end
    $finish;
  end

endmodule
